@@ rtl/rsc_pkg.sv @@
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, constants and digit coding for the radix string converter.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int RADIX_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int STORE_DEPTH = 32;
    localparam int STORE_AW  = 5;
    localparam int COUNT_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_RADIX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_RADIX = 1'd1;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] SRC_RESET = 6'd2;
    localparam logic [RADIX_W-1:0] DST_RESET = 6'd16;

    localparam logic [7:0] DIGIT_BASE = 8'd48;
    localparam logic [7:0] LOWER_BASE = 8'd87;
    localparam logic [7:0] UPPER_BASE = 8'd55;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_out;
        logic       error;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic fold;
        logic clear;
        logic store_zero;
        logic div_load;
        logic div_step;
        logic store_digit;
        logic emit_rd;
        logic err_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic err;
        logic acc_zero;
        logic div_last;
        logic quo_zero;
        logic store_full;
        logic ptr_zero;
    } t_sts;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] v;
        v = r;
        if (r < RADIX_MIN) v = RADIX_MIN;
        if (r > RADIX_MAX) v = RADIX_MAX;
        return v;
    endfunction

    // {valid, value}
    function automatic logic [RADIX_W:0] digit_value(input logic [7:0] c);
        logic [RADIX_W:0] v;
        logic [7:0]       t;
        v = '0;
        t = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - DIGIT_BASE;
            v = {1'b1, t[RADIX_W-1:0]};
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            t = c - LOWER_BASE;
            v = {1'b1, t[RADIX_W-1:0]};
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            t = c - UPPER_BASE;
            v = {1'b1, t[RADIX_W-1:0]};
        end
        return v;
    endfunction

    function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [7:0] c;
        if (d <= 6'd9) c = {2'b00, d} + DIGIT_BASE;
        else           c = {2'b00, d} + LOWER_BASE;
        return c;
    endfunction

endpackage

@@ rtl/rsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsc_ctrl
// Sequencer: load characters, then divide out digits and play them back.
// ----------------------------------------------------------------------------
module rsc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_last,
    input  rsc_pkg::t_sts      i_sts,
    output rsc_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.fold = 1'b1;
                    if (i_last) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.err) begin
                    o_cmd.err_out = 1'b1;
                    o_cmd.clear   = 1'b1;
                    n_state       = S_IDLE;
                end else if (i_sts.acc_zero) begin
                    o_cmd.store_zero = 1'b1;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.store_digit = 1'b1;
                if (i_sts.quo_zero) begin
                    n_state = S_EMIT;
                end else if (i_sts.store_full) begin
                    o_cmd.err_out = 1'b1;
                    o_cmd.clear   = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_EMIT: begin
                o_cmd.emit_rd = 1'b1;
                if (i_sts.ptr_zero) begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

@@ rtl/rsc_datapath.sv @@
// ----------------------------------------------------------------------------
// rsc_datapath
// Horner accumulator, bit-serial divider, digit store and result register.
// ----------------------------------------------------------------------------
module rsc_datapath #(
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rsc_pkg::RADIX_W-1:0]        i_cfg_data,
    input  rsc_pkg::t_in_item                  i_item,
    input  rsc_pkg::t_cmd                      i_cmd,
    output rsc_pkg::t_sts                      o_sts,
    output logic                               o_valid,
    output rsc_pkg::t_out_item                 o_result
);

    localparam int RW    = rsc_pkg::RADIX_W;
    localparam int PW    = VALUE_BITS + RW + 1;
    localparam int BIT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    logic [RW-1:0]                 r_src_radix;
    logic [RW-1:0]                 r_dst_radix;
    logic [VALUE_BITS-1:0]         r_acc;
    logic                          r_err;
    logic [VALUE_BITS-1:0]         r_quo;
    logic [RW-1:0]                 r_rem;
    logic [BIT_W-1:0]              r_bit;
    logic [rsc_pkg::COUNT_W-1:0]   r_cnt;
    logic [rsc_pkg::STORE_AW-1:0]  r_ptr;
    logic [RW-1:0]                 r_mem [rsc_pkg::STORE_DEPTH];
    logic [RW-1:0]                 r_rd_data;
    logic                          r_out_vld;
    logic                          r_out_last;
    logic                          r_out_err;

    logic [RW-1:0] w_src;
    logic [RW-1:0] w_dst;
    logic [RW:0]   w_dig;
    logic [PW-1:0] w_prod;
    logic          w_ovf;
    logic [RW:0]   w_rem_sh;
    logic          w_ge;
    logic [RW:0]   w_rem_sub;

    assign w_src  = rsc_pkg::clamp_radix(r_src_radix);
    assign w_dst  = rsc_pkg::clamp_radix(r_dst_radix);
    assign w_dig  = rsc_pkg::digit_value(i_item.char_in);
    assign w_prod = PW'(r_acc) * PW'(w_src) + PW'(w_dig[RW-1:0]);
    assign w_ovf  = |w_prod[PW-1:VALUE_BITS];

    assign w_rem_sh  = {r_rem, r_quo[VALUE_BITS-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, w_dst});
    assign w_rem_sub = w_rem_sh - {1'b0, w_dst};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_radix <= rsc_pkg::SRC_RESET;
            r_dst_radix <= rsc_pkg::DST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rsc_pkg::CFG_SRC_RADIX: r_src_radix <= i_cfg_data;
                rsc_pkg::CFG_DST_RADIX: r_dst_radix <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accumulator, error flag, digit count, playback pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_err <= 1'b0;
            r_cnt <= '0;
            r_ptr <= '0;
        end else begin
            if (i_cmd.fold && !r_err) begin
                if (!w_dig[RW] || w_ovf) r_err <= 1'b1;
                else                     r_acc <= w_prod[VALUE_BITS-1:0];
            end
            if (i_cmd.store_zero) begin
                r_cnt <= rsc_pkg::COUNT_W'(1);
                r_ptr <= '0;
            end
            if (i_cmd.store_digit) begin
                r_cnt <= r_cnt + 1'b1;
                r_ptr <= r_cnt[rsc_pkg::STORE_AW-1:0];
            end
            if (i_cmd.emit_rd) begin
                r_ptr <= r_ptr - 1'b1;
            end
            if (i_cmd.clear) begin
                r_acc <= '0;
                r_err <= 1'b0;
                r_cnt <= '0;
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_quo <= r_acc;
            r_rem <= '0;
            r_bit <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub[RW-1:0] : w_rem_sh[RW-1:0];
            r_bit <= r_bit + 1'b1;
        end else if (i_cmd.store_digit) begin
            r_rem <= '0;
            r_bit <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_zero) begin
            r_mem[0] <= '0;
        end else if (i_cmd.store_digit) begin
            r_mem[r_cnt[rsc_pkg::STORE_AW-1:0]] <= r_rem;
        end
        if (i_cmd.emit_rd) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_out_last <= 1'b0;
            r_out_err  <= 1'b0;
        end else begin
            r_out_vld  <= i_cmd.emit_rd || i_cmd.err_out;
            r_out_last <= i_cmd.err_out || (r_ptr == '0);
            r_out_err  <= i_cmd.err_out;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_result.char_out = r_out_err ? 8'd0 : rsc_pkg::digit_char(r_rd_data);
    assign o_result.last_out = r_out_last;
    assign o_result.error    = r_out_err;

    assign o_sts.err        = r_err;
    assign o_sts.acc_zero   = (r_acc == '0);
    assign o_sts.div_last   = (r_bit == BIT_W'(VALUE_BITS - 1));
    assign o_sts.quo_zero   = (r_quo == '0);
    assign o_sts.store_full = (r_cnt == rsc_pkg::COUNT_W'(rsc_pkg::STORE_DEPTH - 1));
    assign o_sts.ptr_zero   = (r_ptr == '0);

endmodule

@@ rtl/radix_string_converter.sv @@
// ----------------------------------------------------------------------------
// radix_string_converter
// ASCII numeral in, numeral in another radix out, one digit per strobe beat.
// ----------------------------------------------------------------------------
// Characters: one per cycle, accepted while o_busy is low.
// After the last character: a check state, then the bit-serial divider per output
// digit, then digits at one per cycle, each shown the cycle after its read.
// Error (or a full digit store) and a zero value each give one registered beat.
// Results cannot be stalled. Synchronous active-low reset clears all control
// state but the divider's bit count, and sets src_radix 2, dst_radix 16.
module radix_string_converter #(
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  rsc_pkg::t_in_item              i_item,
    output logic                           o_valid,
    output rsc_pkg::t_out_item             o_result,
    input  logic                           i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsc_pkg::RADIX_W-1:0]    i_cfg_data
);

    rsc_pkg::t_cmd w_cmd;
    rsc_pkg::t_sts w_sts;

    rsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_last  (i_item.last_in),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    rsc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule
